/* src/fclq_pkg.sv */
// Shared types and constants for the single-server queue controller.
`default_nettype none

package fclq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 64;

  localparam int ID_W   = 16;
  localparam int TIME_W = 32;
  localparam int QLEN_W = 7;
  localparam int ENTRY_W = ID_W + TIME_W;

  localparam logic OP_ARRIVAL  = 1'b0;
  localparam logic OP_COMPLETE = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;   // capture the input transaction and issue the store read
    logic commit;   // update queue state and load the result register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free; // result register empty or being taken this cycle
  } status_t;

endpackage

`default_nettype wire

/* src/fclq_ctrl.sv */
// Controller state machine: sequences accept and commit for each event.
`default_nettype none

module fclq_ctrl
  import fclq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold until the result register can take the new result
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/fclq_dp.sv */
// Datapath: waiting store, queue pointers, server state and result register.
`default_nettype none

module fclq_dp
  import fclq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  output status_t                status,
  input  wire logic              cfg_write,
  input  wire logic              cfg_data,
  input  wire logic              opcode,
  input  wire logic [ID_W-1:0]   packet_id,
  input  wire logic [TIME_W-1:0] now,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   departed_valid,
  output logic [ID_W-1:0]        departed_id,
  output logic [TIME_W-1:0]      response_time,
  output logic                   started_valid,
  output logic [ID_W-1:0]        started_id,
  output logic [TIME_W-1:0]      queueing_time,
  output logic [QLEN_W-1:0]      queue_length,
  output logic                   server_busy,
  output logic                   dropped,
  output logic                   idle_completion_error
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(QUEUE_DEPTH - 1);

  logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];

  logic               lcfs_mode;
  logic [PTR_W-1:0]   oldest;
  logic [PTR_W-1:0]   oldest_next;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic               busy;
  logic               busy_next;
  logic [ID_W-1:0]    served_id;
  logic [ID_W-1:0]    served_id_next;
  logic [TIME_W-1:0]  served_arr;
  logic [TIME_W-1:0]  served_arr_next;

  logic               op_q;
  logic [ID_W-1:0]    pid_q;
  logic [TIME_W-1:0]  now_q;
  logic [ENTRY_W-1:0] rd_data;

  logic [SUM_W-1:0]   tail_sum;
  logic [SUM_W-1:0]   tail_wrap;
  logic [PTR_W-1:0]   tail;
  logic [PTR_W-1:0]   newest;
  logic [PTR_W-1:0]   rd_addr;
  logic               full;
  logic               mem_we;
  logic [ID_W-1:0]    rd_id;
  logic [TIME_W-1:0]  rd_arr;
  logic [31:0]        cnt_ext;

  logic               dep_v;
  logic [ID_W-1:0]    dep_id;
  logic [TIME_W-1:0]  resp;
  logic               st_v;
  logic [ID_W-1:0]    st_id;
  logic [TIME_W-1:0]  qtime;
  logic               drop;
  logic               err;

  // Ring positions: next free slot and newest waiting entry.
  assign tail_sum  = SUM_W'(oldest) + SUM_W'(count);
  assign tail_wrap = (tail_sum >= DEPTH_S) ? tail_sum - DEPTH_S : tail_sum;
  assign tail      = tail_wrap[PTR_W-1:0];
  assign newest    = (tail == '0) ? LAST_P : tail - 1'b1;
  assign rd_addr   = lcfs_mode ? newest : oldest;
  assign full      = (count == DEPTH_C);

  assign rd_id  = rd_data[ENTRY_W-1:TIME_W];
  assign rd_arr = rd_data[TIME_W-1:0];

  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      lcfs_mode <= 1'b0;
    end else if (cfg_write) begin
      lcfs_mode <= cfg_data;
    end
  end

  // Capture the event and read the candidate entry in the same cycle.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q    <= opcode;
      pid_q   <= packet_id;
      now_q   <= now;
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail] <= {pid_q, now_q};
    end
  end

  always_comb begin
    oldest_next     = oldest;
    count_next      = count;
    busy_next       = busy;
    served_id_next  = served_id;
    served_arr_next = served_arr;
    mem_we          = 1'b0;
    dep_v           = 1'b0;
    dep_id          = '0;
    resp            = '0;
    st_v            = 1'b0;
    st_id           = '0;
    qtime           = '0;
    drop            = 1'b0;
    err             = 1'b0;
    if (op_q == OP_ARRIVAL) begin
      if (!busy) begin
        busy_next       = 1'b1;
        served_id_next  = pid_q;
        served_arr_next = now_q;
        st_v            = 1'b1;
        st_id           = pid_q;
      end else if (full) begin
        drop = 1'b1;
      end else begin
        mem_we     = cmd.commit;
        count_next = count + 1'b1;
      end
    end else begin
      if (!busy) begin
        err = 1'b1;
      end else begin
        dep_v  = 1'b1;
        dep_id = served_id;
        resp   = now_q - served_arr;
        if (count == '0) begin
          busy_next = 1'b0;
        end else begin
          if (!lcfs_mode) begin
            oldest_next = (oldest == LAST_P) ? '0 : oldest + 1'b1;
          end
          count_next      = count - 1'b1;
          served_id_next  = rd_id;
          served_arr_next = rd_arr;
          st_v            = 1'b1;
          st_id           = rd_id;
          qtime           = now_q - rd_arr;
        end
      end
    end
  end

  assign cnt_ext = 32'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest     <= '0;
      count      <= '0;
      busy       <= 1'b0;
      served_id  <= '0;
      served_arr <= '0;
    end else if (cmd.commit) begin
      oldest     <= oldest_next;
      count      <= count_next;
      busy       <= busy_next;
      served_id  <= served_id_next;
      served_arr <= served_arr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      departed_valid        <= dep_v;
      departed_id           <= dep_id;
      response_time         <= resp;
      started_valid         <= st_v;
      started_id            <= st_id;
      queueing_time         <= qtime;
      queue_length          <= cnt_ext[QLEN_W-1:0];
      server_busy           <= busy_next;
      dropped               <= drop;
      idle_completion_error <= err;
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("waiting count above store depth");

  a_idle_empty : assert property (@(posedge clk) disable iff (rst)
    !busy |-> count == '0)
    else $error("packets waiting while server idle");

  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || !out_stall))
    else $error("result overwritten while stalled");

  a_cmd_exclusive : assert property (@(posedge clk) disable iff (rst)
    !(cmd.accept && cmd.commit))
    else $error("accept and commit in the same cycle");

  a_drop_only_full : assert property (@(posedge clk) disable iff (rst)
    cmd.commit && drop |=> count == DEPTH_C)
    else $error("drop without a full store");

endmodule

`default_nettype wire

/* src/fcfs_lcfs_single_server_queue.sv */
// Top level of the single-server FCFS/LCFS queue controller.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall   | opcode, packet_id, now
//   out     | output    | out_valid / out_stall | departure, start, queue status
//   cfg     | input     | cfg_valid / cfg_ready | cfg_data (lcfs_mode)
//
// Each event is handled in an accept step, which reads one store entry, and then
// a commit step, which updates the queue state and loads the result register.
// The commit waits while a previous result is held by out_stall, and no new
// event is accepted until the current one has committed.
// Reset is synchronous; it empties the queue and idles the server. The
// waiting store is not cleared; an entry is only used once it is counted.
// cfg_ready is always high; write lcfs_mode only while no event is in flight.
`default_nettype none

module fcfs_lcfs_single_server_queue
  import fclq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              opcode,
  input  wire logic [ID_W-1:0]   packet_id,
  input  wire logic [TIME_W-1:0] now,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   departed_valid,
  output logic [ID_W-1:0]        departed_id,
  output logic [TIME_W-1:0]      response_time,
  output logic                   started_valid,
  output logic [ID_W-1:0]        started_id,
  output logic [TIME_W-1:0]      queueing_time,
  output logic [QLEN_W-1:0]      queue_length,
  output logic                   server_busy,
  output logic                   dropped,
  output logic                   idle_completion_error
);

  cmd_t    cmd;
  status_t status;
  logic    cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  fclq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  fclq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk                   (clk),
    .rst                   (rst),
    .cmd                   (cmd),
    .status                (status),
    .cfg_write             (cfg_write),
    .cfg_data              (cfg_data),
    .opcode                (opcode),
    .packet_id             (packet_id),
    .now                   (now),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .departed_valid        (departed_valid),
    .departed_id           (departed_id),
    .response_time         (response_time),
    .started_valid         (started_valid),
    .started_id            (started_id),
    .queueing_time         (queueing_time),
    .queue_length          (queue_length),
    .server_busy           (server_busy),
    .dropped               (dropped),
    .idle_completion_error (idle_completion_error)
  );

endmodule

`default_nettype wire
